>>> hw/rtl/ppqmc_pkg.sv
// Package for the tick-to-MIDI-clock converter: codes, defaults, FSM state type
// and the command/status structs between controller and datapath.
// No dependencies.
package ppqmc_pkg;

   // Default widths and register reset values
   localparam int DEF_TICK_BITS = 32;
   localparam int DEF_PPQ_BITS  = 15;
   localparam int DEF_PPQ       = 96;
   localparam int BEAT_BITS     = 5;

   // Input kinds carried in tuser
   typedef logic [1:0] func_type;
   localparam func_type FUNC_TICK  = 2'd0;
   localparam func_type FUNC_DRAIN = 2'd1;
   localparam func_type FUNC_ARM   = 2'd2;

   // Pending clock request codes
   typedef logic [1:0] clk_req_type;
   localparam clk_req_type REQ_NONE  = 2'd0;
   localparam clk_req_type REQ_CLOCK = 2'd1;
   localparam clk_req_type REQ_ARMED = 2'd2;
   localparam clk_req_type REQ_START = 2'd3;

   // MIDI realtime bytes
   localparam logic [7:0] BYTE_START = 8'hFA;
   localparam logic [7:0] BYTE_CLOCK = 8'hF8;

   // Configuration register indexes
   localparam int CSR_IDX_BITS = 1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PPQ   = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TOTAL = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_EVAL,
      ST_COMMIT,
      ST_WAIT_START,
      ST_WAIT_LAST
   } state_type;

   typedef struct packed {
      logic load;       // capture tick, start divider
      logic div_step;   // one restoring division step
      logic eval;       // end-of-song check, wrap, product
      logic commit;     // clock compare and state update
      logic arm;        // arm song start
      logic clear_req;  // pending request taken by a drain
      logic put_start;  // load START byte into output register
      logic put_clock;  // load CLOCK byte into output register
   } cmd_type;

   typedef struct packed {
      logic        div_done;
      logic        rsp_taken;
      clk_req_type clk_req;
   } stat_type;

endpackage

>>> hw/rtl/ppqmc_ctrl.sv
// Controller FSM for the tick-to-MIDI-clock converter: sequences the divider,
// the tick evaluation and the byte output. Depends on ppqmc_pkg.
module ppqmc_ctrl
   import ppqmc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  func_type req_tuser,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  FUNC_TICK: state_in = ST_DIV;
                  FUNC_DRAIN: begin
                     if (stat.clk_req == REQ_START) begin
                        state_in = ST_WAIT_START;
                     end else if (stat.clk_req == REQ_CLOCK) begin
                        state_in = ST_WAIT_LAST;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_DIV: begin
            if (stat.div_done) state_in = ST_EVAL;
         end
         ST_EVAL:   state_in = ST_COMMIT;
         ST_COMMIT: state_in = ST_IDLE;
         ST_WAIT_START: begin
            if (stat.rsp_taken) state_in = ST_WAIT_LAST;
         end
         ST_WAIT_LAST: begin
            if (stat.rsp_taken) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  FUNC_TICK: cmd.load = 1'b1;
                  FUNC_ARM:  cmd.arm  = 1'b1;
                  FUNC_DRAIN: begin
                     if (stat.clk_req == REQ_START) begin
                        cmd.put_start = 1'b1;
                        cmd.clear_req = 1'b1;
                     end else if (stat.clk_req == REQ_CLOCK) begin
                        cmd.put_clock = 1'b1;
                        cmd.clear_req = 1'b1;
                     end
                  end
                  default: cmd = '0;
               endcase
            end
         end
         ST_DIV:    cmd.div_step = ~stat.div_done;
         ST_EVAL:   cmd.eval     = 1'b1;
         ST_COMMIT: cmd.commit   = 1'b1;
         ST_WAIT_START: begin
            if (stat.rsp_taken) cmd.put_clock = 1'b1;
         end
         ST_WAIT_LAST: cmd = '0;
         default:      cmd = '0;
      endcase
   end

endmodule

>>> hw/rtl/ppqmc_dpath.sv
// Datapath for the tick-to-MIDI-clock converter: config registers, two-lane
// restoring divider, clock state and output register. Depends on ppqmc_pkg.
module ppqmc_dpath
   import ppqmc_pkg::*;
#(
   parameter int TICK_BITS = DEF_TICK_BITS,
   parameter int PPQ_BITS  = DEF_PPQ_BITS,
   parameter int CSR_W     = (TICK_BITS > PPQ_BITS) ? TICK_BITS : PPQ_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output stat_type                stat,
   input  logic [TICK_BITS-1:0]    tick_in,
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CSR_W-1:0]        csr_wdata,
   input  logic                    rsp_tready,
   output logic                    rsp_tvalid,
   output logic [7:0]              rsp_tdata,
   output logic                    rsp_tlast
);

   localparam int CNT_W  = $clog2(TICK_BITS + 1);
   localparam int PROD_W = PPQ_BITS + BEAT_BITS;

   // Configuration
   logic [PPQ_BITS-1:0]  ppq_ff, ppq_in;
   logic [TICK_BITS-1:0] total_ff, total_in;
   logic [PPQ_BITS-1:0]  divisor;

   // Divider lanes: tick and song total, same divisor
   logic [TICK_BITS-1:0] tnum_ff, tnum_in, snum_ff, snum_in;
   logic [PPQ_BITS-1:0]  trem_ff, trem_in, srem_ff, srem_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [PPQ_BITS:0]    twide, swide;
   logic                 tge, sge;

   // Clock state
   clk_req_type           req_ff, req_in;
   logic [BEAT_BITS-1:0]  beat_ff, beat_in;
   logic [PPQ_BITS-1:0]   prior_ff, prior_in;

   // Evaluation stage
   logic                  ignored_ff, ignored_in;
   logic                  wrap_ff, wrap_in;
   logic [BEAT_BITS-1:0]  beat_eff_ff, beat_eff_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [PROD_W-1:0]     idx24;
   logic                  pass;

   // Output register
   logic                  valid_ff, valid_in;
   logic [7:0]            byte_ff, byte_in;
   logic                  last_ff, last_in;

   assign divisor = (ppq_ff == '0) ? PPQ_BITS'(1) : ppq_ff;

   // Configuration writes
   always_comb begin
      ppq_in   = ppq_ff;
      total_in = total_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PPQ:   ppq_in   = csr_wdata[PPQ_BITS-1:0];
            CSR_TOTAL: total_in = csr_wdata[TICK_BITS-1:0];
            default:   ppq_in   = ppq_ff;
         endcase
      end
   end

   // One restoring step per lane
   assign twide = {trem_ff, tnum_ff[TICK_BITS-1]};
   assign swide = {srem_ff, snum_ff[TICK_BITS-1]};
   assign tge   = twide >= {1'b0, divisor};
   assign sge   = swide >= {1'b0, divisor};

   always_comb begin
      tnum_in = tnum_ff;
      snum_in = snum_ff;
      trem_in = trem_ff;
      srem_in = srem_ff;
      cnt_in  = cnt_ff;
      if (cmd.load) begin
         tnum_in = tick_in;
         snum_in = total_ff;
         trem_in = '0;
         srem_in = '0;
         cnt_in  = CNT_W'(TICK_BITS);
      end else if (cmd.div_step) begin
         tnum_in = {tnum_ff[TICK_BITS-2:0], tge};
         snum_in = {snum_ff[TICK_BITS-2:0], sge};
         trem_in = tge ? PPQ_BITS'(twide - {1'b0, divisor}) : twide[PPQ_BITS-1:0];
         srem_in = sge ? PPQ_BITS'(swide - {1'b0, divisor}) : swide[PPQ_BITS-1:0];
         cnt_in  = cnt_ff - 1'b1;
      end
   end

   // Evaluation: end of song, beat wrap, count * ppq
   always_comb begin
      ignored_in  = ignored_ff;
      wrap_in     = wrap_ff;
      beat_eff_in = beat_eff_ff;
      prod_in     = prod_ff;
      if (cmd.eval) begin
         ignored_in  = (tnum_ff > snum_ff) ||
                       ((tnum_ff == snum_ff) && (srem_ff != (divisor - 1'b1)));
         wrap_in     = prior_ff > trem_ff;
         beat_eff_in = (prior_ff > trem_ff) ? BEAT_BITS'(1) : beat_ff;
         prod_in     = PROD_W'(beat_eff_in) * PROD_W'(divisor);
      end
   end

   // index > floor(count*ppq/24)  <=>  count*ppq < 24*index
   assign idx24 = (PROD_W'(trem_ff) << 4) + (PROD_W'(trem_ff) << 3);
   assign pass  = prod_ff < idx24;

   // Clock request state
   always_comb begin
      req_in   = req_ff;
      beat_in  = beat_ff;
      prior_in = prior_ff;
      if (cmd.arm) begin
         req_in = REQ_ARMED;
      end else if (cmd.clear_req) begin
         req_in = REQ_NONE;
      end else if (cmd.commit) begin
         if (ignored_ff) begin
            prior_in = trem_ff;
         end else if (req_ff == REQ_ARMED) begin
            req_in   = REQ_START;
            beat_in  = BEAT_BITS'(1);
            prior_in = '0;
         end else begin
            if (wrap_ff) begin
               beat_in = BEAT_BITS'(1);
               req_in  = REQ_CLOCK;
            end
            if (pass) begin
               beat_in = beat_eff_ff + 1'b1;
               req_in  = REQ_CLOCK;
            end
            prior_in = trem_ff;
         end
      end
   end

   // Output word register
   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (cmd.put_start) begin
         valid_in = 1'b1;
         byte_in  = BYTE_START;
         last_in  = 1'b0;
      end else if (cmd.put_clock) begin
         valid_in = 1'b1;
         byte_in  = BYTE_CLOCK;
         last_in  = 1'b1;
      end else if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ppq_ff   <= PPQ_BITS'(DEF_PPQ);
         total_ff <= '0;
         req_ff   <= REQ_NONE;
         beat_ff  <= '0;
         prior_ff <= '0;
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         ppq_ff   <= ppq_in;
         total_ff <= total_in;
         req_ff   <= req_in;
         beat_ff  <= beat_in;
         prior_ff <= prior_in;
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      tnum_ff     <= tnum_in;
      snum_ff     <= snum_in;
      trem_ff     <= trem_in;
      srem_ff     <= srem_in;
      ignored_ff  <= ignored_in;
      wrap_ff     <= wrap_in;
      beat_eff_ff <= beat_eff_in;
      prod_ff     <= prod_in;
      byte_ff     <= byte_in;
      last_ff     <= last_in;
   end

   assign stat.div_done  = (cnt_ff == '0);
   assign stat.rsp_taken = valid_ff & rsp_tready;
   assign stat.clk_req   = req_ff;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;

endmodule

>>> hw/rtl/ppq_tick_to_midi_clock.sv
// Tick-to-MIDI-clock converter, top level. A tick word passes through the
// bit-serial divider that reduces tick and song length by the resolution,
// then evaluation and commit; a drain holds until the output side has taken
// each byte it queues. One word at a time.
// Synchronous active-high reset: resolution 96, song length 0, nothing pending.
module ppq_tick_to_midi_clock
   import ppqmc_pkg::*;
#(
   parameter int TICK_BITS = DEF_TICK_BITS,
   parameter int PPQ_BITS  = DEF_PPQ_BITS,
   parameter int TDATA_W   = ((TICK_BITS + 7) / 8) * 8,
   parameter int CSR_W     = (TICK_BITS > PPQ_BITS) ? TICK_BITS : PPQ_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [TDATA_W-1:0]      req_tdata,   // tick_value
   input  logic [1:0]              req_tuser,   // func
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [7:0]              rsp_tdata,   // midi_byte
   output logic                    rsp_tlast,
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CSR_W-1:0]        csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   ppqmc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   ppqmc_dpath #(
      .TICK_BITS (TICK_BITS),
      .PPQ_BITS  (PPQ_BITS),
      .CSR_W     (CSR_W)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .tick_in    (req_tdata[TICK_BITS-1:0]),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> test/ppq_midi_checker.sv
// Checker for the tick-to-MIDI-clock converter: predicts the MIDI realtime
// bytes from accepted request words and register writes, then compares them.
// Depends on ppqmc_pkg for input kinds, request codes and byte values.
module ppq_midi_checker
   import ppqmc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tready,
   input  logic [31:0]             req_tdata,   // tick_value
   input  logic [1:0]              req_tuser,   // func
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic [7:0]              rsp_tdata,   // midi_byte
   input  logic                    rsp_tlast,
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [31:0]             csr_wdata,
   output int                      fail_count,
   output int                      pending
);

   typedef struct packed {
      logic [7:0] midi_byte;
      logic       last;
   } midi_word_type;

   midi_word_type  expected_words[$];
   midi_word_type  exp_word;

   // shadow registers and clock state
   logic [14:0] ppq_reg;
   logic [31:0] song_len_reg;
   clk_req_type clk_req;
   logic [4:0]  beat_clocks;
   logic [14:0] prior_index;

   int errors;
   int reported;

   task automatic note_mismatch(input string what, input logic [7:0] exp_v,
                                input logic [7:0] act_v);
      errors++;
      if (reported < 10) begin
         reported++;
         $display("mismatch %0s: expected %0h got %0h", what, exp_v, act_v);
      end
   endtask

   // Advance the clock state by one word; a drain queues the pending bytes
   task automatic step_clock_model(input logic [1:0] f, input logic [31:0] tick);
      logic [63:0] res;
      logic [63:0] idx;
      logic [63:0] tq;
      logic [63:0] q;
      logic [63:0] r;
      res = (ppq_reg == 15'd0) ? 64'd1 : {49'd0, ppq_reg};
      case (f)
         FUNC_TICK: begin
            idx = tick % res;
            tq  = tick / res;
            q   = song_len_reg / res;
            r   = song_len_reg % res;
            // at or past the song end rounded down to a whole beat
            if ((tq > q) || ((tq == q) && (r != res - 64'd1))) begin
               prior_index = idx[14:0];
            end else if (clk_req == REQ_ARMED) begin
               clk_req = REQ_START;
               beat_clocks = 5'd1;
               prior_index = '0;
            end else begin
               // beat wrapped: clock count restarts
               if ({49'd0, prior_index} > idx) begin
                  beat_clocks = 5'd1;
                  clk_req = REQ_CLOCK;
               end
               if (idx > ({59'd0, beat_clocks} * res) / 64'd24) begin
                  beat_clocks = beat_clocks + 5'd1;
                  clk_req = REQ_CLOCK;
               end
               prior_index = idx[14:0];
            end
         end
         FUNC_ARM: begin
            clk_req = REQ_ARMED;
         end
         FUNC_DRAIN: begin
            if (clk_req == REQ_START) begin
               expected_words.push_back('{BYTE_START, 1'b0});
               expected_words.push_back('{BYTE_CLOCK, 1'b1});
               clk_req = REQ_NONE;
            end else if (clk_req == REQ_CLOCK) begin
               expected_words.push_back('{BYTE_CLOCK, 1'b1});
               clk_req = REQ_NONE;
            end
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         ppq_reg = 15'(DEF_PPQ);
         song_len_reg = '0;
         clk_req = REQ_NONE;
         beat_clocks = '0;
         prior_index = '0;
         expected_words.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_PPQ) ppq_reg = csr_wdata[14:0];
            else if (csr_index == CSR_TOTAL) song_len_reg = csr_wdata;
         end
         if (req_tvalid && req_tready) step_clock_model(req_tuser, req_tdata);
         // compare each output word with the oldest expected one
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               errors++;
               if (reported < 10) begin
                  reported++;
                  $display("unexpected word: byte %0h last %0b", rsp_tdata, rsp_tlast);
               end
            end else begin
               exp_word = expected_words.pop_front();
               if (rsp_tdata != exp_word.midi_byte)
                  note_mismatch("midi_byte", exp_word.midi_byte, rsp_tdata);
               if (rsp_tlast != exp_word.last)
                  note_mismatch("last", {7'd0, exp_word.last}, {7'd0, rsp_tlast});
            end
         end
      end
      pending <= expected_words.size();
      fail_count <= errors;
   end

endmodule

>>> test/ppq_tick_to_midi_clock_tb.sv
// Testbench top for the tick-to-MIDI-clock converter: clock, reset, register
// writes, request stimulus and output backpressure; gives the verdict.
// Depends on ppqmc_pkg, ppq_tick_to_midi_clock and ppq_midi_checker.
module ppq_tick_to_midi_clock_tb;
   import ppqmc_pkg::*;

   localparam int TICK_BITS = 32;
   localparam int STALL_LIMIT = 5000;
   localparam func_type FUNC_SPARE = 2'd3;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [31:0]             req_tdata;   // tick_value
   logic [1:0]              req_tuser;   // func
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [7:0]              rsp_tdata;   // midi_byte
   logic                    rsp_tlast;
   logic                    csr_we;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [31:0]             csr_wdata;

   int fail_count;
   int pending;

   int send_idle_pct;
   int recv_stall_pct;
   int hold_cycles;
   int idle_cycles;
   logic [14:0] cur_ppq;
   logic [31:0] cur_total;

   ppq_tick_to_midi_clock dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   ppq_midi_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // output side: random stalls, or a long hold-off when one is asked for
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog: cycles without any accepted word
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // offer one word, with a random gap first; valid stays up for the next word
   task automatic offer_word(input logic [1:0] f, input logic [31:0] t);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser <= f;
      req_tdata <= t;
      do @(posedge clock); while (!req_tready);
   endtask

   // stop offering, wait for every expected byte, then let a tick finish
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (TICK_BITS + 16) @(posedge clock);
   endtask

   task automatic program_clock(input logic [14:0] ppq, input logic [31:0] total);
      csr_we <= 1'b1;
      csr_index <= CSR_PPQ;
      csr_wdata <= {17'd0, ppq};
      @(posedge clock);
      csr_index <= CSR_TOTAL;
      csr_wdata <= total;
      @(posedge clock);
      csr_we <= 1'b0;
      cur_ppq = ppq;
      cur_total = total;
   endtask

   // arm, then mostly advancing ticks and drains, with some noise mixed in
   task automatic play_song(input int len);
      logic [31:0] t;
      int step;
      int pick;
      t = $urandom_range(cur_total, 0);
      step = (cur_ppq == 15'd0) ? 1 : int'(cur_ppq) / 8 + 1;
      offer_word(FUNC_ARM, $urandom);
      for (int k = 0; k < len; k++) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            t = t + $urandom_range(step, 0);
            offer_word(FUNC_TICK, t);
         end else if (pick < 85) begin
            offer_word(FUNC_DRAIN, $urandom);
         end else if (pick < 90) begin
            offer_word(FUNC_TICK, $urandom);
         end else if (pick < 94) begin
            t = t - $urandom_range(step, 1);
            offer_word(FUNC_TICK, t);
         end else if (pick < 97) begin
            offer_word(FUNC_SPARE, $urandom);
         end else begin
            offer_word(FUNC_ARM, $urandom);
         end
      end
   endtask

   initial begin
      int sent;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = FUNC_TICK;
      csr_we = 1'b0;
      csr_index = CSR_PPQ;
      csr_wdata = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_cycles = 0;
      cur_ppq = 15'(DEF_PPQ);
      cur_total = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: zero song length ignores every tick
      offer_word(FUNC_TICK, 32'h0);
      offer_word(FUNC_TICK, 32'hFFFF_FFFF);
      offer_word(FUNC_DRAIN, 32'h0);
      offer_word(FUNC_SPARE, 32'hFFFF_FFFF);
      offer_word(FUNC_ARM, 32'h0);
      offer_word(FUNC_TICK, 32'd5);
      offer_word(FUNC_DRAIN, 32'h0);
      wait_quiet();

      // zero resolution acts as one; drain while armed, pending start kept past a later tick
      program_clock(15'd0, 32'hFFFF_FFFF);
      offer_word(FUNC_ARM, 32'h0);
      offer_word(FUNC_DRAIN, 32'h0);
      offer_word(FUNC_TICK, 32'd10);
      offer_word(FUNC_TICK, 32'd11);
      offer_word(FUNC_DRAIN, 32'h0);
      offer_word(FUNC_ARM, 32'h0);
      offer_word(FUNC_TICK, 32'd100);
      offer_word(FUNC_DRAIN, 32'h0);
      offer_word(FUNC_DRAIN, 32'h0);
      offer_word(FUNC_TICK, 32'hFFFF_FFFF);
      offer_word(FUNC_DRAIN, 32'h0);
      wait_quiet();

      // widest resolution at the top of the tick range
      program_clock(15'd32767, 32'hFFFF_FFFF);
      offer_word(FUNC_ARM, 32'h0);
      offer_word(FUNC_TICK, 32'hFFFF_FFFF);
      offer_word(FUNC_TICK, 32'h0);
      offer_word(FUNC_TICK, 32'd32766);
      offer_word(FUNC_TICK, 32'hFFFF_0000);
      offer_word(FUNC_DRAIN, 32'h0);
      offer_word(FUNC_DRAIN, 32'h0);
      wait_quiet();

      // random phases: each idling mode under two settings
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
            default: begin send_idle_pct = 37; recv_stall_pct = 37; end
         endcase
         case (ph)
            0: program_clock(15'd96, 32'hFFFF_FFFF);
            1: program_clock(15'd24, $urandom);
            2: program_clock(15'd1, 32'd2000);
            3: program_clock(15'd32767, 32'hFFFF_FFFF);
            4: program_clock(15'($urandom_range(200, 1)), $urandom_range(5000, 200));
            5: program_clock(15'($urandom_range(32767, 1)), $urandom);
            6: program_clock(15'd3, 32'hFFFF_FFFE);
            default: program_clock(15'd96, 32'd383);
         endcase
         // long output hold-off while words keep coming
         if (ph == 0) hold_cycles = 400;
         sent = 0;
         while (sent < 42) begin
            int len;
            len = $urandom_range(30, 10);
            play_song(len);
            sent += len + 1;
         end
         wait_quiet();
      end

      if (fail_count == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
